// ===== design/blr_pkg.sv =====
// Shared types, widths and sequencer states for the line rasterizer.
// Used by the channel interfaces and the core; depends on nothing.
package blr_pkg;

  localparam int COORD_BITS = 6;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int DEC_BITS   = COORD_BITS + 4;
  localparam int EXT_BITS   = DEC_BITS - DIFF_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;
  typedef logic        [COORD_BITS-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

endpackage

// ===== design/blr_if.sv =====
// Valid/ready channels for line requests and emitted cells.
// Depends on blr_pkg for the coordinate type.
interface blr_in_if;
  logic            valid;
  logic            ready;
  blr_pkg::coord_t start_x;
  blr_pkg::coord_t start_y;
  blr_pkg::coord_t end_x;
  blr_pkg::coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

interface blr_out_if;
  logic            valid;
  logic            ready;
  blr_pkg::coord_t pixel_x;
  blr_pkg::coord_t pixel_y;
  logic            last;

  modport source (output valid, output pixel_x, output pixel_y, output last,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input last,
                  output ready);
endinterface

// ===== design/bresenham_line_rasterizer_core.sv =====
// Midpoint line rasterizer: one request word in, one word per grid cell out.
// Sequence: a request is accepted in idle, the setup state follows, then the first cell is shown.
// Throughput: max(|dx|,|dy|)+1 cells at one per cycle while out is ready;
// no new request is taken until setup and all cells are done and the block is idle.
// Reset: synchronous active-low rst_n returns the sequencer to idle.
// Depends on blr_pkg and the channel interfaces in blr_if.sv.
module bresenham_line_rasterizer_core (
  input  logic      clk,
  input  logic      rst_n,
  blr_in_if.sink    in_if,
  blr_out_if.source out_if
);

  blr_pkg::state_t state_r, state_nxt;

  blr_pkg::coord_t x_r, x_nxt;
  blr_pkg::coord_t y_r, y_nxt;
  blr_pkg::coord_t xe_r, xe_nxt;
  blr_pkg::coord_t ye_r, ye_nxt;
  blr_pkg::dec_t   d_r, d_nxt;
  blr_pkg::dec_t   inc_min_r, inc_min_nxt;
  blr_pkg::dec_t   inc_maj_r, inc_maj_nxt;
  blr_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            steep_r, steep_nxt;
  logic            fall_r, fall_nxt;
  logic            min_pos_r, min_pos_nxt;

  logic            in_fire;
  logic            out_fire;
  logic            is_last;
  logic            swap;
  blr_pkg::diff_t  dx;
  blr_pkg::diff_t  dy;
  blr_pkg::diff_t  ady;
  blr_pkg::dec_t   dx_e;
  blr_pkg::dec_t   dy_e;
  logic            steep;
  logic            minor;
  blr_pkg::dec_t   inc_sel;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign is_last  = (cnt_r == '0);
  assign swap     = in_if.start_x > in_if.end_x;

  // setup arithmetic
  always_comb begin
    dx    = {xe_r[blr_pkg::COORD_BITS-1], xe_r} - {x_r[blr_pkg::COORD_BITS-1], x_r};
    dy    = {ye_r[blr_pkg::COORD_BITS-1], ye_r} - {y_r[blr_pkg::COORD_BITS-1], y_r};
    ady   = dy[blr_pkg::DIFF_BITS-1] ? -dy : dy;
    steep = ady > dx;
    dx_e  = {{blr_pkg::EXT_BITS{dx[blr_pkg::DIFF_BITS-1]}}, dx};
    dy_e  = {{blr_pkg::EXT_BITS{dy[blr_pkg::DIFF_BITS-1]}}, dy};
  end

  // shared decision step
  always_comb begin
    minor   = min_pos_r ? (d_r > 0) : (d_r <= 0);
    inc_sel = minor ? inc_min_r : inc_maj_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      blr_pkg::ST_IDLE:  if (in_fire) state_nxt = blr_pkg::ST_SETUP;
      blr_pkg::ST_SETUP: state_nxt = blr_pkg::ST_RUN;
      blr_pkg::ST_RUN:   if (out_fire && is_last) state_nxt = blr_pkg::ST_IDLE;
      default:           state_nxt = blr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready    = 1'b0;
    out_if.valid   = 1'b0;
    out_if.pixel_x = x_r;
    out_if.pixel_y = y_r;
    out_if.last    = is_last;
    case (state_r)
      blr_pkg::ST_IDLE: in_if.ready  = 1'b1;
      blr_pkg::ST_RUN:  out_if.valid = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    x_nxt       = x_r;
    y_nxt       = y_r;
    xe_nxt      = xe_r;
    ye_nxt      = ye_r;
    d_nxt       = d_r;
    inc_min_nxt = inc_min_r;
    inc_maj_nxt = inc_maj_r;
    cnt_nxt     = cnt_r;
    steep_nxt   = steep_r;
    fall_nxt    = fall_r;
    min_pos_nxt = min_pos_r;
    case (state_r)
      blr_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_nxt  = swap ? in_if.end_x   : in_if.start_x;
          y_nxt  = swap ? in_if.end_y   : in_if.start_y;
          xe_nxt = swap ? in_if.start_x : in_if.end_x;
          ye_nxt = swap ? in_if.start_y : in_if.end_y;
        end
      end
      blr_pkg::ST_SETUP: begin
        steep_nxt = steep;
        fall_nxt  = dy[blr_pkg::DIFF_BITS-1];
        cnt_nxt   = steep ? ady[blr_pkg::COORD_BITS-1:0] : dx[blr_pkg::COORD_BITS-1:0];
        case ({dy[blr_pkg::DIFF_BITS-1], steep})
          2'b00: begin
            d_nxt       = (dy_e <<< 1) - dx_e;
            inc_min_nxt = (dy_e - dx_e) <<< 1;
            inc_maj_nxt = dy_e <<< 1;
            min_pos_nxt = 1'b1;
          end
          2'b01: begin
            d_nxt       = dy_e - (dx_e <<< 1);
            inc_min_nxt = (dy_e - dx_e) <<< 1;
            inc_maj_nxt = -(dx_e <<< 1);
            min_pos_nxt = 1'b0;
          end
          2'b10: begin
            d_nxt       = (dy_e <<< 1) + dx_e;
            inc_min_nxt = (dy_e + dx_e) <<< 1;
            inc_maj_nxt = dy_e <<< 1;
            min_pos_nxt = 1'b0;
          end
          default: begin
            d_nxt       = dy_e + (dx_e <<< 1);
            inc_min_nxt = (dy_e + dx_e) <<< 1;
            inc_maj_nxt = dx_e <<< 1;
            min_pos_nxt = 1'b1;
          end
        endcase
      end
      blr_pkg::ST_RUN: begin
        if (out_fire && !is_last) begin
          d_nxt   = d_r + inc_sel;
          cnt_nxt = cnt_r - 1'b1;
          if (!steep_r || minor) x_nxt = x_r + 1'b1;
          if (steep_r || minor)  y_nxt = fall_r ? y_r - 1'b1 : y_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= blr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    xe_r      <= xe_nxt;
    ye_r      <= ye_nxt;
    d_r       <= d_nxt;
    inc_min_r <= inc_min_nxt;
    inc_maj_r <= inc_maj_nxt;
    cnt_r     <= cnt_nxt;
    steep_r   <= steep_nxt;
    fall_r    <= fall_nxt;
    min_pos_r <= min_pos_nxt;
  end

endmodule
